// ----- sv/perc_pkg.sv -----
`default_nettype none
package perc_pkg;

  localparam int MAX_INPUTS_DEF = 8;

  localparam int AI_W   = 4;
  localparam int RATE_W = 16;
  localparam int FEAT_W = 16;
  localparam int WGT_W  = 32;
  localparam int SUM_W  = 48;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_INPUTS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEARN_RATE    = 2'd1;

  localparam logic [AI_W-1:0]   ACTIVE_INPUTS_RST = 4'd2;
  localparam logic [RATE_W-1:0] LEARN_RATE_RST    = 16'd6554;

  localparam logic [1:0] ERR_ZERO = 2'b00;
  localparam logic [1:0] ERR_POS  = 2'b01;
  localparam logic [1:0] ERR_NEG  = 2'b11;

  // Clamp a 34-bit signed sum to the signed 32-bit range.
  function automatic logic [WGT_W-1:0] sat32(input logic [33:0] v);
    logic [WGT_W-1:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/perceptron_train_predict_unit.sv -----
// Sequence: each feature passes through weight read, shared multiply and accumulate; a
//   sample's final one also adds the bias, applies the step and registers the result. A
//   nonzero training error then walks each trained weight through the shared multiplier
//   and moves the bias. The block takes no new feature until it is back in idle. A waiting
//   result holds the block at the end of the final feature until it is taken.
// Reset (rst, synchronous): weight valid bits, bias, sum and count clear; registers take defaults.
`default_nettype none
module perceptron_train_predict_unit
  import perc_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  // configuration write channel
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]        cfg_index,
  input  wire  [CFG_DATA_W-1:0]         cfg_data,
  // input items, one feature each
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           req_type,
  input  wire  signed [FEAT_W-1:0]      feature,
  input  wire                           target,
  // result items, one per completed sample
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          prediction,
  output logic signed [SUM_W-1:0]       pre_activation,
  output logic signed [1:0]             error_sign
);

  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic [7:0] MAX8 = 8'(MAX_INPUTS);

  // Sequencer: one-hot states around the shared multiplier.
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,  // take a feature
    S_MUL     = 8'b0000_0010,  // weight times feature
    S_ACC     = 8'b0000_0100,  // add product into running sum
    S_SUM     = 8'b0000_1000,  // add bias, step, issue result
    S_UPD_RD  = 8'b0001_0000,  // read weight and buffered feature
    S_UPD_MUL = 8'b0010_0000,  // rate times feature
    S_UPD_ADD = 8'b0100_0000,  // write back saturated weight
    S_BIAS    = 8'b1000_0000   // move bias by rate
  } state_t;

  state_t state;

  // Configuration registers
  logic [AI_W-1:0]   active_inputs;
  logic [RATE_W-1:0] learn_rate;

  // Sample state
  logic [CW-1:0]           feature_count;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           last_ptr;
  logic signed [SUM_W-1:0] dot_accum;
  logic [WGT_W-1:0]        bias_value;
  logic                    mode;
  logic                    tgt;
  logic                    err_neg;
  logic signed [FEAT_W-1:0] feat_reg;

  // Weight store with per-entry valid bits (unwritten entries read as zero),
  // feature buffer with no reset.
  logic [WGT_W-1:0]  weights [MAX_INPUTS];
  logic [FEAT_W-1:0] feature_buffer [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] w_valid;
  logic [WGT_W-1:0]  w_rd;
  logic              w_vld_rd;
  logic [FEAT_W-1:0] fb_rd;
  logic [CW-1:0]     rd_addr;
  logic [WGT_W-1:0]  w_eff;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] prod_next;
  logic signed [48:0] prod;

  logic              accept;
  logic              last_feat;
  logic [7:0]        n_eff;
  logic signed [SUM_W-1:0] acc_next;
  logic signed [SUM_W-1:0] sum48;
  logic              pred;
  logic [1:0]        err_code;
  logic              out_free;
  logic signed [48:0] upd_val;
  logic signed [48:0] upd_sh;
  logic [33:0]       w_sum;
  logic [33:0]       b_sum;
  logic [33:0]       rate_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // Out-of-range lengths: zero counts as one, above the store depth as full.
  always_comb begin
    if (active_inputs == '0) begin
      n_eff = 8'd1;
    end else if ({4'b0, active_inputs} > MAX8) begin
      n_eff = MAX8;
    end else begin
      n_eff = {4'b0, active_inputs};
    end
  end

  assign last_feat = ({{(8-CW){1'b0}}, ptr} + 8'd1) >= n_eff;

  // Read at the next feature's slot while idle, else at the walk pointer.
  assign rd_addr = (state == S_IDLE) ? feature_count : ptr;
  assign w_eff   = w_vld_rd ? w_rd : '0;

  always_comb begin
    if (state == S_MUL) begin
      mul_a = signed'(w_eff);
      mul_b = {feat_reg[FEAT_W-1], feat_reg};
    end else begin
      mul_a = signed'({16'b0, learn_rate});
      mul_b = {fb_rd[FEAT_W-1], fb_rd};
    end
    prod_next = mul_a * mul_b;
  end

  // Floor shift by 8 of the Q24.24 product gives the Q32.16 term.
  assign acc_next = dot_accum + {{7{prod[48]}}, prod[48:8]};

  always_comb begin
    sum48 = dot_accum + {{(SUM_W-WGT_W){bias_value[WGT_W-1]}}, bias_value};
    pred  = ~sum48[SUM_W-1];
    if (mode && tgt && !pred) begin
      err_code = ERR_POS;
    end else if (mode && !tgt && pred) begin
      err_code = ERR_NEG;
    end else begin
      err_code = ERR_ZERO;
    end
  end

  // Weight step: negate before the floor shift so rounding matches error times rate.
  always_comb begin
    upd_val  = err_neg ? -prod : prod;
    upd_sh   = upd_val >>> 8;
    w_sum    = {{2{w_eff[WGT_W-1]}}, w_eff} + upd_sh[33:0];
    rate_ext = {18'b0, learn_rate};
    b_sum    = {{2{bias_value[WGT_W-1]}}, bias_value} + (err_neg ? -rate_ext : rate_ext);
  end

  // Control and state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_inputs <= ACTIVE_INPUTS_RST;
      learn_rate    <= LEARN_RATE_RST;
      feature_count <= '0;
      ptr           <= '0;
      dot_accum     <= '0;
      bias_value    <= '0;
      w_valid       <= '0;
      w_vld_rd      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      w_vld_rd <= w_valid[rd_addr];

      if (cfg_valid) begin
        case (cfg_index)
          REG_ACTIVE_INPUTS: active_inputs <= cfg_data[AI_W-1:0];
          REG_LEARN_RATE:    learn_rate    <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end

      // raise the result when a sample completes, drop it once taken
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ptr   <= feature_count;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          dot_accum <= acc_next;
          if (last_feat) begin
            state <= S_SUM;
          end else begin
            feature_count <= ptr + 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SUM: begin
          // hold until the output register is free
          if (out_free) begin
            dot_accum     <= '0;
            feature_count <= '0;
            if (err_code != ERR_ZERO) begin
              ptr   <= '0;
              state <= S_UPD_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_UPD_RD: begin
          state <= S_UPD_MUL;
        end
        S_UPD_MUL: begin
          state <= S_UPD_ADD;
        end
        S_UPD_ADD: begin
          w_valid[ptr] <= 1'b1;
          if (ptr == last_ptr) begin
            state <= S_BIAS;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_UPD_RD;
          end
        end
        S_BIAS: begin
          bias_value <= sat32(b_sum);
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      feat_reg <= feature;
      mode     <= req_type;
      tgt      <= target;
    end
    if (state == S_MUL || state == S_UPD_MUL) begin
      prod <= prod_next;
    end
    if (state == S_SUM && out_free) begin
      prediction     <= pred;
      pre_activation <= sum48;
      error_sign     <= err_code;
      err_neg        <= err_code[1];
      last_ptr       <= ptr;
    end
  end

  // Weight and feature stores
  always_ff @(posedge clk) begin
    if (state == S_UPD_ADD) begin
      weights[ptr] <= sat32(w_sum);
    end
    if (accept) begin
      feature_buffer[feature_count] <= feature;
    end
    w_rd  <= weights[rd_addr];
    fb_rd <= feature_buffer[ptr];
  end

endmodule
`default_nettype wire

// ----- tb/sv/perceptron_train_predict_checker.sv -----
module perceptron_train_predict_checker
  import perc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     req_type,
  input  logic signed [FEAT_W-1:0] feature,
  input  logic                     target,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     prediction,
  input  logic signed [SUM_W-1:0]  pre_activation,
  input  logic signed [1:0]        error_sign,
  output int                       fail_count,
  output int                       results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             pred;
    logic [SUM_W-1:0] pre_act;
    logic [1:0]       err;
  } neuron_result_t;

  localparam int     LANES      = MAX_INPUTS_DEF;
  localparam longint WGT_MAX    = 64'sd2147483647;
  localparam longint WGT_MIN    = -64'sd2147483648;
  localparam int     REPORT_CAP = 100;

  logic [AI_W-1:0]          n_active;
  logic [RATE_W-1:0]        rate;
  logic signed [WGT_W-1:0]  wgt [LANES];
  logic signed [WGT_W-1:0]  bias;
  logic signed [FEAT_W-1:0] fbuf [LANES];
  longint                   dot_sum;
  int                       fed;
  neuron_result_t           neuron_results [$];

  function automatic logic signed [WGT_W-1:0] clamp_weight(input longint v);
    if (v > WGT_MAX) return WGT_MAX[WGT_W-1:0];
    if (v < WGT_MIN) return WGT_MIN[WGT_W-1:0];
    return v[WGT_W-1:0];
  endfunction

  // Take one feature; on the last one of a sample, queue the neuron's output and learn.
  function automatic void feed_feature(input logic rq, input logic signed [FEAT_W-1:0] f,
                                       input logic tg);
    int             n;
    int             pos;
    longint         sum;
    longint         err;
    longint         step;
    neuron_result_t r;
    n = int'(n_active);
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    pos = (fed >= LANES) ? LANES - 1 : fed;
    fbuf[pos] = f;
    dot_sum += (longint'(wgt[pos]) * longint'(f)) >>> 8;
    if (pos + 1 < n) begin
      fed = pos + 1;
      return;
    end
    sum = dot_sum + longint'(bias);
    r.pred = (sum >= 0);
    err = rq ? ((tg ? 1 : 0) - (r.pred ? 1 : 0)) : 0;
    r.pre_act = sum[SUM_W-1:0];
    r.err = (err == 0) ? ERR_ZERO : ((err > 0) ? ERR_POS : ERR_NEG);
    neuron_results.push_back(r);
    if (err != 0) begin
      for (int j = 0; j <= pos; j++) begin
        step = (err * longint'(rate) * longint'(fbuf[j])) >>> 8;
        wgt[j] = clamp_weight(longint'(wgt[j]) + step);
      end
      bias = clamp_weight(longint'(bias) + err * longint'(rate));
    end
    dot_sum = 0;
    fed = 0;
  endfunction

  function automatic void flag_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    neuron_result_t want;
    if (rst) begin
      n_active = ACTIVE_INPUTS_RST;
      rate = LEARN_RATE_RST;
      for (int i = 0; i < LANES; i++) begin
        wgt[i] = '0;
        fbuf[i] = '0;
      end
      bias = '0;
      dot_sum = 0;
      fed = 0;
      neuron_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_INPUTS: n_active = cfg_data[AI_W-1:0];
          REG_LEARN_RATE:    rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) feed_feature(req_type, feature, target);
      if (out_valid && !out_stall) begin
        if (neuron_results.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $error("unexpected result: prediction %0b pre_activation %0h error_sign %0h",
                   prediction, pre_activation, error_sign);
          fail_count++;
        end else begin
          want = neuron_results.pop_front();
          flag_field("prediction", 64'(want.pred), 64'(prediction));
          flag_field("pre_activation", 64'(want.pre_act), 64'(unsigned'(pre_activation)));
          flag_field("error_sign", 64'(want.err), 64'(unsigned'(error_sign)));
        end
      end
    end
    results_owed = neuron_results.size();
  end

endmodule

// ----- tb/sv/perceptron_train_predict_unit_tb.sv -----
module perceptron_train_predict_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import perc_pkg::*;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int ITEM_TARGET   = 925;     // directed items plus about 900 random ones
  localparam int SETTLE_CYCLES = 64;      // covers a feature plus a full training walk
  localparam int LONG_HOLD     = 400;     // receiver hold-off that backs the block up
  localparam int CYCLE_LIMIT   = 500000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = 1'b0;
  logic signed [FEAT_W-1:0] feature = '0;
  logic                     target = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     prediction;
  logic signed [SUM_W-1:0]  pre_activation;
  logic signed [1:0]        error_sign;

  int checker_fails;
  int results_owed;

  // Traffic shaping, changed per phase by the stimulus process.
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_long_hold = 0;
  int items_sent = 0;

  always #4 clk = ~clk;

  perceptron_train_predict_unit dut (.*);

  perceptron_train_predict_checker u_checker (
    .*,
    .fail_count   (checker_fails),
    .results_owed (results_owed)
  );

  // Offer one feature item and hold it until the block takes it. Valid is left high
  // on return so a back-to-back item keeps it up without a same-step drop.
  task automatic send_feature(input logic rq, input logic signed [FEAT_W-1:0] f,
                              input logic tg);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    feature  <= f;
    target   <= tg;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back. Sample the
  // owed count at the falling edge, after the checker has settled.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // Drain, then give the block time to finish a training walk that produced no result.
  task automatic settle_idle();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both registers in random order; the sample length word carries junk in
  // its unused upper bits. Optionally poke an undecoded index first.
  task automatic program_regs(input logic [AI_W-1:0] ai, input logic [RATE_W-1:0] lr,
                              input bit with_spare);
    logic [CFG_DATA_W-1:0] ai_word;
    ai_word = {(CFG_DATA_W-AI_W)'($urandom), ai};
    if (with_spare)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ACTIVE_INPUTS, ai_word);
      write_reg(REG_LEARN_RATE, lr);
    end else begin
      write_reg(REG_LEARN_RATE, lr);
      write_reg(REG_ACTIVE_INPUTS, ai_word);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly full-range features, with the rails and values around zero mixed in.
  function automatic logic signed [FEAT_W-1:0] pick_feature();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return FEAT_W'($urandom_range(0, 8)) - FEAT_W'(4);
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // Result side: draw a hold-off per result, or take a long one when asked.
  initial begin : result_sink
    int hold;
    forever begin
      if (rx_long_hold > 0) begin
        hold = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        hold = rx_gaps ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [AI_W-1:0]   ai;
    logic [RATE_W-1:0] lr;
    int                phase;
    int                phase_len;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: two features per sample, rate about 0.1. Weights are zero, so
    // the first sample sums to exactly zero and must predict 1.
    send_feature(1'b0, 16'sh7fff, 1'b0);
    send_feature(1'b0, 16'sh8000, 1'b1);
    // Train against the zero-sum prediction; req_type on the non-final item is a decoy.
    send_feature(1'b0, 16'sh7fff, 1'b1);
    send_feature(1'b1, 16'sh8000, 1'b0);
    send_feature(1'b1, 16'sh0100, 1'b0);
    send_feature(1'b1, 16'shff00, 1'b1);

    // Zero length counts as one feature; full-scale rate.
    settle_idle();
    program_regs(4'd0, 16'hffff, 1'b0);
    send_feature(1'b1, 16'sh7fff, 1'b0);
    send_feature(1'b1, 16'sh8000, 1'b1);
    send_feature(1'b0, 16'sh0000, 1'b1);
    send_feature(1'b1, 16'sh0000, 1'b0);

    // Length above the buffer depth clamps to eight features.
    settle_idle();
    program_regs(4'd15, 16'hffff, 1'b0);
    for (int k = 0; k < 8; k++)
      send_feature(1'b1, k[0] ? 16'sh8000 : 16'sh7fff, 1'b1);

    // Shrink the length mid-sample: three features already in, new length two, so
    // the next feature closes the sample and all four positions learn.
    settle_idle();
    program_regs(4'd4, LEARN_RATE_RST, 1'b0);
    send_feature(1'b1, 16'sh4000, 1'b0);
    send_feature(1'b1, 16'shc000, 1'b0);
    send_feature(1'b1, 16'sh0001, 1'b0);
    settle_idle();
    program_regs(4'd2, LEARN_RATE_RST, 1'b1);
    send_feature(1'b1, 16'shffff, 1'b1);

    // Zero rate: errors still show, weights move by nothing. Undecoded index poked too.
    settle_idle();
    program_regs(4'd2, 16'h0000, 1'b1);
    send_feature(1'b1, 16'sh1234, 1'b0);
    send_feature(1'b1, 16'sh8000, 1'b1);

    // Random phases: new settings each time, extremes favored. Phase lengths are
    // random, so a phase often ends mid-sample and the next length applies to it.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      case ($urandom_range(0, 5))
        0: ai = 4'd1;
        1: ai = 4'd8;
        2: ai = AI_W'($urandom_range(9, 15));
        3: ai = 4'd0;
        default: ai = AI_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 4))
        0: lr = '0;
        1: lr = '1;
        2: lr = LEARN_RATE_RST;
        default: lr = RATE_W'($urandom);
      endcase
      program_regs(ai, lr, $urandom_range(0, 3) == 0);

      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // Hold the result side off while the sender streams back to back, so the
        // block backs up and stalls its input.
        tx_gaps = 1'b0;
        rx_long_hold = LONG_HOLD;
      end

      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        send_feature($urandom_range(0, 3) != 0, pick_feature(), $urandom_range(0, 1));
        // Now and then pause the sender until the block has drained.
        if ($urandom_range(0, 63) == 0) wait_results_drained();
      end
      phase++;
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (checker_fails == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/perc_pkg.sv
sv/perceptron_train_predict_unit.sv
tb/sv/perceptron_train_predict_checker.sv
tb/sv/perceptron_train_predict_unit_tb.sv
